@@ rtl/tlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, widths and reset constants of the traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

   // Build-time defaults of the top-level parameters
   localparam int NIGHT_HALF_MS_DEF  = 500;
   localparam int POT_FULL_SCALE_DEF = 4095;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 12;
   localparam int MS_W     = 16;
   localparam int SPAN_W   = SAMPLE_W + MS_W;   // saturated pot times green span
   localparam int LAMP_W   = 3;
   localparam int AUX_W    = 4;
   localparam int CODE_W   = 3;
   localparam int CSR_IDX_W = 3;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] NIGHT_THR_RST  = 12'd1500;
   localparam logic [MS_W-1:0]     GREEN_MIN_RST  = 16'd3000;
   localparam logic [MS_W-1:0]     GREEN_MAX_RST  = 16'd10000;
   localparam logic [MS_W-1:0]     AMBER_RST      = 16'd2000;
   localparam logic [MS_W-1:0]     AUX_BLINK_RST  = 16'd300;

   // Lamp patterns: bit2 red, bit1 yellow, bit0 green
   localparam logic [LAMP_W-1:0] LAMP_OFF        = 3'b000;
   localparam logic [LAMP_W-1:0] LAMP_RED        = 3'b100;
   localparam logic [LAMP_W-1:0] LAMP_RED_YELLOW = 3'b110;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW     = 3'b010;
   localparam logic [LAMP_W-1:0] LAMP_GREEN      = 3'b001;
   localparam int                LAMP_YELLOW_BIT = 1;

   localparam logic [AUX_W-1:0] AUX_OFF  = 4'b0000;
   localparam logic [AUX_W-1:0] AUX_ALL  = 4'b1111;
   localparam logic [AUX_W-1:0] AUX_ODD  = 4'b0101;
   localparam logic [AUX_W-1:0] AUX_EVEN = 4'b1010;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIGHT_THR = 3'd0,
      CSR_GREEN_MIN = 3'd1,
      CSR_GREEN_MAX = 3'd2,
      CSR_AMBER     = 3'd3,
      CSR_AUX_BLINK = 3'd4
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_RED        = 3'd0,
      CODE_RED_YELLOW = 3'd1,
      CODE_GREEN      = 3'd2,
      CODE_YELLOW     = 3'd3,
      CODE_NIGHT      = 3'd4
   } phase_code_type;

   typedef enum logic [4:0] {
      PH_RED        = 5'b00001,
      PH_RED_YELLOW = 5'b00010,
      PH_GREEN      = 5'b00100,
      PH_YELLOW     = 5'b01000,
      PH_NIGHT      = 5'b10000
   } phase_type;

   // One poll as it enters the block
   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic [SAMPLE_W-1:0] pot_sample;
      logic [SAMPLE_W-1:0] light_sample;
   } poll_type;

   // One poll after the stateless front end
   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic [SAMPLE_W-1:0] light_sample;
      logic [SPAN_W-1:0]   pot_span;    // saturated pot times green span
      logic                flash_odd;   // bit 0 of now_ms / NIGHT_HALF_MS
   } prep_type;

   function automatic phase_code_type phase_code(input phase_type ph);
      phase_code_type code;
      unique case (ph)
         PH_RED:        code = CODE_RED;
         PH_RED_YELLOW: code = CODE_RED_YELLOW;
         PH_GREEN:      code = CODE_GREEN;
         PH_YELLOW:     code = CODE_YELLOW;
         PH_NIGHT:      code = CODE_NIGHT;
         default:       code = CODE_RED;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/traffic_light_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// traffic_light_controller
// Two-way traffic light sequencer with night flashing, one result per poll.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one poll per transaction: time in ms and two 12-bit ADC
//          samples (pot sets the green time, light selects night mode).
//   rsp_*  returns one transaction per poll: lamps of both signals, the four
//          aux LEDs and the phase that drove them.
//   csr_*  writes a register (index 0..4); indexes above four are dropped.
//          Write only while no poll is in flight. csr_ready is always high.
// Pipeline: a poll passes three front-end stages (input register, pot scaling
//   with the flash-parity reciprocal multiply, and its correction) and then
//   the phase sequencer, which loads the result register. One poll per cycle
//   is sustained while rsp_tready keeps the result register free; the phase
//   state loop closes within the cycle that loads the result register.
// Stall: when rsp_tready is low the result holds; the front end keeps
//   accepting polls until its three stages are full, then req_tready drops.
// Reset: synchronous, active high. Phase returns to red with start time 0,
//   all lamps and aux LEDs go dark, both toggles and the blink time clear,
//   and the registers take their default values.
// ----------------------------------------------------------------------------
module traffic_light_controller
   import tlc_pkg::*;
#(
   parameter int NIGHT_HALF_MS  = NIGHT_HALF_MS_DEF,
   parameter int POT_FULL_SCALE = POT_FULL_SCALE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // poll in
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [55:0]          req_tdata,   // now_ms[31:0], pot_sample[43:32],
                                                  // light_sample[55:44]
   // result out
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // lamps_a[2:0], lamps_b[5:3],
                                                  // aux_leds[9:6], phase_code[12:10]
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MS_W-1:0]      csr_data
);

   localparam int PFS_W  = $clog2(POT_FULL_SCALE + 1);
   localparam int DP1_W  = MS_W + 1;
   localparam int CMP_W  = (DP1_W + PFS_W > SPAN_W) ? DP1_W + PFS_W : SPAN_W;
   localparam logic [PFS_W-1:0] POT_FS = PFS_W'(POT_FULL_SCALE);

   // Configuration registers
   logic [SAMPLE_W-1:0] night_thr_ff;
   logic [MS_W-1:0]     green_min_ff, green_max_ff, amber_ff, aux_blink_ff;

   // Sequencer state; the lamp latches double as the result register
   phase_type           phase_ff, phase_in;
   logic [TIME_W-1:0]   phase_start_ff, phase_start_in;
   logic [LAMP_W-1:0]   lamps_a_ff, lamps_a_in;
   logic [LAMP_W-1:0]   lamps_b_ff, lamps_b_in;
   logic [AUX_W-1:0]    aux_ff, aux_in;
   logic                ry_toggle_ff, ry_toggle_in;
   logic                alt_toggle_ff, alt_toggle_in;
   logic [TIME_W-1:0]   last_alt_ff, last_alt_in;
   phase_code_type      code_ff;
   phase_type           shown;
   logic                rsp_valid_ff, rsp_valid_in;

   poll_type            req_poll;
   prep_type            prep;
   logic                prep_valid, load_rsp, rsp_free;

   logic                night, leave_night;
   logic [TIME_W-1:0]   start_eff, elapsed, past_min, since_alt;
   logic [MS_W-1:0]     past_min_sat;
   logic [DP1_W-1:0]    past_min_p1;
   logic [DP1_W+PFS_W-1:0] green_prod;
   logic                green_done, amber_done, blink_due;

   assign req_poll.now_ms       = req_tdata[31:0];
   assign req_poll.pot_sample   = req_tdata[43:32];
   assign req_poll.light_sample = req_tdata[55:44];

   // The result register is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   tlc_prep #(
      .NIGHT_HALF_MS  (NIGHT_HALF_MS),
      .POT_FULL_SCALE (POT_FULL_SCALE)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_poll   (req_poll),
      .green_min (green_min_ff),
      .green_max (green_max_ff),
      .out_valid (prep_valid),
      .out_ready (rsp_free),
      .out_prep  (prep)
   );

   assign load_rsp     = prep_valid && rsp_free;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Register writes; any index outside the list is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         night_thr_ff <= NIGHT_THR_RST;
         green_min_ff <= GREEN_MIN_RST;
         green_max_ff <= GREEN_MAX_RST;
         amber_ff     <= AMBER_RST;
         aux_blink_ff <= AUX_BLINK_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NIGHT_THR: night_thr_ff <= csr_data[SAMPLE_W-1:0];
            CSR_GREEN_MIN: green_min_ff <= csr_data;
            CSR_GREEN_MAX: green_max_ff <= csr_data;
            CSR_AMBER:     amber_ff     <= csr_data;
            CSR_AUX_BLINK: aux_blink_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Night entry and exit; leaving night restarts red at the poll time
   assign night       = prep.light_sample < night_thr_ff;
   assign leave_night = !night && (phase_ff == PH_NIGHT);
   assign start_eff   = leave_night ? prep.now_ms : phase_start_ff;
   assign elapsed     = prep.now_ms - start_eff;
   assign since_alt   = prep.now_ms - last_alt_ff;

   // Green timeout without a divider:
   //   elapsed >= min + floor(span_prod / FS)
   //   <=> elapsed >= min and (elapsed - min + 1) * FS > span_prod.
   // The green extension never exceeds 65535, so clamp the excess there.
   assign past_min     = elapsed - {16'b0, green_min_ff};
   assign past_min_sat = (past_min[TIME_W-1:MS_W] != '0) ? '1 : past_min[MS_W-1:0];
   assign past_min_p1  = {1'b0, past_min_sat} + DP1_W'(1);
   assign green_prod   = past_min_p1 * POT_FS;
   assign green_done   = (elapsed >= {16'b0, green_min_ff}) &&
                         (CMP_W'(green_prod) > CMP_W'(prep.pot_span));
   assign amber_done   = elapsed >= {16'b0, amber_ff};
   assign blink_due    = since_alt > {16'b0, aux_blink_ff};

   always_comb begin
      phase_in       = phase_ff;
      phase_start_in = start_eff;
      lamps_a_in     = lamps_a_ff;
      lamps_b_in     = lamps_b_ff;
      aux_in         = aux_ff;
      ry_toggle_in   = ry_toggle_ff;
      alt_toggle_in  = alt_toggle_ff;
      last_alt_in    = last_alt_ff;

      if (night) begin
         if (phase_ff != PH_NIGHT) begin
            // go dark; toggles and blink time are kept
            phase_in   = PH_NIGHT;
            lamps_a_in = LAMP_OFF;
            lamps_b_in = LAMP_OFF;
            aux_in     = AUX_OFF;
         end
      end else if (leave_night) begin
         phase_in = PH_RED;
      end

      shown = phase_in;

      unique case (shown)
         PH_NIGHT: begin
            // both yellows lit on even half-periods
            lamps_a_in[LAMP_YELLOW_BIT] = !prep.flash_odd;
            lamps_b_in[LAMP_YELLOW_BIT] = !prep.flash_odd;
         end
         PH_RED: begin
            lamps_a_in = LAMP_RED;
            lamps_b_in = LAMP_GREEN;
            aux_in     = AUX_ODD;
            if (green_done) begin
               phase_in       = PH_RED_YELLOW;
               phase_start_in = prep.now_ms;
            end
         end
         PH_RED_YELLOW: begin
            lamps_a_in   = LAMP_RED_YELLOW;
            lamps_b_in   = LAMP_YELLOW;
            ry_toggle_in = !ry_toggle_ff;
            aux_in       = ry_toggle_ff ? AUX_OFF : AUX_ALL;
            if (amber_done) begin
               phase_in       = PH_GREEN;
               phase_start_in = prep.now_ms;
            end
         end
         PH_GREEN: begin
            lamps_a_in = LAMP_GREEN;
            lamps_b_in = LAMP_RED;
            aux_in     = AUX_EVEN;
            if (green_done) begin
               phase_in       = PH_YELLOW;
               phase_start_in = prep.now_ms;
            end
         end
         PH_YELLOW: begin
            lamps_a_in = LAMP_YELLOW;
            lamps_b_in = LAMP_RED_YELLOW;
            if (blink_due) begin
               alt_toggle_in = !alt_toggle_ff;
               aux_in        = alt_toggle_ff ? AUX_EVEN : AUX_ODD;
               last_alt_in   = prep.now_ms;
            end
            if (amber_done) begin
               phase_in       = PH_RED;
               phase_start_in = prep.now_ms;
            end
         end
         default: begin
            // unreachable encoding: fall back to red
            phase_in = PH_RED;
         end
      endcase
   end

   // Advance the sequencer only when its result enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_RED;
         phase_start_ff <= '0;
         lamps_a_ff     <= LAMP_OFF;
         lamps_b_ff     <= LAMP_OFF;
         aux_ff         <= AUX_OFF;
         ry_toggle_ff   <= 1'b0;
         alt_toggle_ff  <= 1'b0;
         last_alt_ff    <= '0;
         code_ff        <= CODE_RED;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load_rsp) begin
            phase_ff       <= phase_in;
            phase_start_ff <= phase_start_in;
            lamps_a_ff     <= lamps_a_in;
            lamps_b_ff     <= lamps_b_in;
            aux_ff         <= aux_in;
            ry_toggle_ff   <= ry_toggle_in;
            alt_toggle_ff  <= alt_toggle_in;
            last_alt_ff    <= last_alt_in;
            code_ff        <= phase_code(shown);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, code_ff, aux_ff, lamps_b_ff, lamps_a_ff};

   // A shown night phase never lights a red or green lamp or an aux LED
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code_ff == CODE_NIGHT) |->
         (lamps_a_ff[2] == 1'b0) && (lamps_a_ff[0] == 1'b0) &&
         (lamps_b_ff[2] == 1'b0) && (lamps_b_ff[0] == 1'b0) && (aux_ff == AUX_OFF))
      else $error("night result shows a non-yellow lamp");

   // A shown red phase drives the fixed red pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code_ff == CODE_RED) |->
         (lamps_a_ff == LAMP_RED) && (lamps_b_ff == LAMP_GREEN) && (aux_ff == AUX_ODD))
      else $error("red result with wrong lamp pattern");

   // A shown green phase drives the fixed green pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code_ff == CODE_GREEN) |->
         (lamps_a_ff == LAMP_GREEN) && (lamps_b_ff == LAMP_RED) && (aux_ff == AUX_EVEN))
      else $error("green result with wrong lamp pattern");

   // The sequencer state moves only together with a new result
   assert property (@(posedge clock) disable iff (reset)
      !$past(load_rsp) && !$past(reset) |->
         $stable(phase_ff) && $stable(phase_start_ff) && $stable(last_alt_ff))
      else $error("sequencer state changed without a result load");

endmodule
`default_nettype wire

@@ rtl/tlc_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_prep
// Stateless front end: scales the pot reading by the green span and finds
// the parity of the night flash half-period, over three registered stages.
// ----------------------------------------------------------------------------
module tlc_prep
   import tlc_pkg::*;
#(
   parameter int NIGHT_HALF_MS  = NIGHT_HALF_MS_DEF,
   parameter int POT_FULL_SCALE = POT_FULL_SCALE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire poll_type         in_poll,
   input  wire logic [MS_W-1:0]  green_min,
   input  wire logic [MS_W-1:0]  green_max,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output prep_type              out_prep
);

   localparam int HALF_W = $clog2(NIGHT_HALF_MS + 1);
   localparam int REM_W  = HALF_W + 1;               // remainder stays below 2*half
   localparam logic [HALF_W-1:0] HALF_C = HALF_W'(NIGHT_HALF_MS);
   localparam logic [TIME_W:0]   RECIP  = (TIME_W + 1)'((64'd1 << TIME_W) / NIGHT_HALF_MS);
   localparam logic [MS_W-1:0]   POT_FS = MS_W'(POT_FULL_SCALE);

   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic [SAMPLE_W-1:0] light_sample;
      logic [SPAN_W-1:0]   pot_span;
      logic [TIME_W-1:0]   quot_est;   // now_ms / half, low by at most one
   } mid_type;

   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   logic      s3_valid_ff, s3_valid_in;
   poll_type  s1_ff;
   mid_type   s2_ff, s2_in;
   prep_type  s3_ff, s3_in;
   logic      ld1, ld2, ld3, rdy2, rdy3;

   logic [SAMPLE_W-1:0]    pot_sat;
   logic [MS_W-1:0]        span;
   logic [2*TIME_W:0]      recip_prod;
   logic [REM_W+HALF_W-1:0] quot_times_half;
   logic [REM_W-1:0]       rem;

   // Ready chain: a stage takes new data when empty or when it moves on
   assign ld3      = s2_valid_ff && rdy3;
   assign rdy3     = !s3_valid_ff || out_ready;
   assign rdy2     = !s2_valid_ff || ld3;
   assign ld2      = s1_valid_ff && rdy2;
   assign in_ready = !s1_valid_ff || ld2;
   assign ld1      = in_valid && in_ready;

   assign s1_valid_in = ld1 ? 1'b1 : (ld2 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = ld2 ? 1'b1 : (ld3 ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = ld3 ? 1'b1 : (out_ready ? 1'b0 : s3_valid_ff);

   // Stage 2: saturate pot, scale by span, reciprocal multiply for the flash
   assign pot_sat = ({4'b0000, s1_ff.pot_sample} > POT_FS) ?
                    SAMPLE_W'(POT_FULL_SCALE) : s1_ff.pot_sample;
   assign span       = (green_max > green_min) ? (green_max - green_min) : '0;
   assign recip_prod = s1_ff.now_ms * RECIP;

   always_comb begin
      s2_in.now_ms       = s1_ff.now_ms;
      s2_in.light_sample = s1_ff.light_sample;
      s2_in.pot_span     = pot_sat * span;
      s2_in.quot_est     = recip_prod[2*TIME_W-1:TIME_W];
   end

   // Stage 3: correct the quotient estimate, keep its parity
   assign quot_times_half = s2_ff.quot_est[REM_W-1:0] * HALF_C;
   assign rem = s2_ff.now_ms[REM_W-1:0] - quot_times_half[REM_W-1:0];

   always_comb begin
      s3_in.now_ms       = s2_ff.now_ms;
      s3_in.light_sample = s2_ff.light_sample;
      s3_in.pot_span     = s2_ff.pot_span;
      s3_in.flash_odd    = s2_ff.quot_est[0] ^ (rem >= REM_W'(NIGHT_HALF_MS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_ff <= in_poll;
      end
      if (ld2) begin
         s2_ff <= s2_in;
      end
      if (ld3) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_prep  = s3_ff;

endmodule
`default_nettype wire

@@ sim/tlc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_checker
// Scoreboard for the traffic light controller. Mirrors the registers and the
// phase sequencer, predicts one result per accepted poll and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module tlc_checker
   import tlc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [55:0]          req_tdata,   // now_ms[31:0], pot_sample[43:32],
                                                  // light_sample[55:44]
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [15:0]          rsp_tdata,   // lamps_a[2:0], lamps_b[5:3],
                                                  // aux_leds[9:6], phase_code[12:10]
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MS_W-1:0]      csr_data,
   output int unsigned               mismatch_count,
   output int unsigned               results_owed
);

   localparam logic [TIME_W-1:0] FLASH_HALF = TIME_W'(NIGHT_HALF_MS_DEF);
   localparam logic [63:0]       POT_FULL   = 64'(POT_FULL_SCALE_DEF);

   // lamps_a sits in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [CODE_W-1:0] phase_code;
      logic [AUX_W-1:0]  aux_leds;
      logic [LAMP_W-1:0] lamps_b;
      logic [LAMP_W-1:0] lamps_a;
   } signal_view_type;

   signal_view_type expected_views[$];

   // register mirror
   logic [SAMPLE_W-1:0] night_thr;
   logic [MS_W-1:0]     green_min;
   logic [MS_W-1:0]     green_max;
   logic [MS_W-1:0]     amber_len;
   logic [MS_W-1:0]     blink_len;

   // sequencer mirror
   phase_code_type      cur_phase;
   logic [TIME_W-1:0]   phase_start;
   logic [LAMP_W-1:0]   lamp_a;
   logic [LAMP_W-1:0]   lamp_b;
   logic [AUX_W-1:0]    aux_latch;
   logic                ry_toggle;
   logic                blink_toggle;
   logic [TIME_W-1:0]   last_blink;

   function automatic signal_view_type advance_signals(input logic [TIME_W-1:0]   now,
                                                       input logic [SAMPLE_W-1:0] pot,
                                                       input logic [SAMPLE_W-1:0] light);
      logic [63:0]       pot_sat;
      logic [63:0]       span;
      logic [TIME_W-1:0] green_len;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] since_blink;
      logic              flash_lit;
      signal_view_type   view;
      pot_sat   = (64'(pot) > POT_FULL) ? POT_FULL : 64'(pot);
      span      = (green_max > green_min) ? 64'(green_max - green_min) : 64'd0;
      green_len = TIME_W'(green_min) + TIME_W'((pot_sat * span) / POT_FULL);

      if (cur_phase > CODE_NIGHT) cur_phase = CODE_RED;

      // night entry darkens every latch; night exit restarts red right now
      if (light < night_thr) begin
         if (cur_phase != CODE_NIGHT) begin
            cur_phase = CODE_NIGHT;
            lamp_a    = LAMP_OFF;
            lamp_b    = LAMP_OFF;
            aux_latch = AUX_OFF;
         end
      end else if (cur_phase == CODE_NIGHT) begin
         cur_phase   = CODE_RED;
         phase_start = now;
      end

      view.phase_code = cur_phase;
      elapsed         = now - phase_start;
      since_blink     = now - last_blink;

      case (cur_phase)
         CODE_NIGHT: begin
            flash_lit = (((now / FLASH_HALF) & TIME_W'(1)) == '0);
            lamp_a[LAMP_YELLOW_BIT] = flash_lit;
            lamp_b[LAMP_YELLOW_BIT] = flash_lit;
         end
         CODE_RED_YELLOW: begin
            lamp_a    = LAMP_RED_YELLOW;
            lamp_b    = LAMP_YELLOW;
            ry_toggle = ~ry_toggle;
            aux_latch = ry_toggle ? AUX_ALL : AUX_OFF;
            if (elapsed >= TIME_W'(amber_len)) begin
               cur_phase   = CODE_GREEN;
               phase_start = now;
            end
         end
         CODE_GREEN: begin
            lamp_a    = LAMP_GREEN;
            lamp_b    = LAMP_RED;
            aux_latch = AUX_EVEN;
            if (elapsed >= green_len) begin
               cur_phase   = CODE_YELLOW;
               phase_start = now;
            end
         end
         CODE_YELLOW: begin
            lamp_a = LAMP_YELLOW;
            lamp_b = LAMP_RED_YELLOW;
            if (since_blink > TIME_W'(blink_len)) begin
               blink_toggle = ~blink_toggle;
               aux_latch    = blink_toggle ? AUX_ODD : AUX_EVEN;
               last_blink   = now;
            end
            if (elapsed >= TIME_W'(amber_len)) begin
               cur_phase   = CODE_RED;
               phase_start = now;
            end
         end
         default: begin
            lamp_a    = LAMP_RED;
            lamp_b    = LAMP_GREEN;
            aux_latch = AUX_ODD;
            if (elapsed >= green_len) begin
               cur_phase   = CODE_RED_YELLOW;
               phase_start = now;
            end
         end
      endcase

      view.lamps_a  = lamp_a;
      view.lamps_b  = lamp_b;
      view.aux_leds = aux_latch;
      return view;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      signal_view_type got;
      signal_view_type want;
      if (reset) begin
         night_thr    = NIGHT_THR_RST;
         green_min    = GREEN_MIN_RST;
         green_max    = GREEN_MAX_RST;
         amber_len    = AMBER_RST;
         blink_len    = AUX_BLINK_RST;
         cur_phase    = CODE_RED;
         phase_start  = '0;
         lamp_a       = LAMP_OFF;
         lamp_b       = LAMP_OFF;
         aux_latch    = AUX_OFF;
         ry_toggle    = 1'b0;
         blink_toggle = 1'b0;
         last_blink   = '0;
         expected_views.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NIGHT_THR: night_thr = csr_data[SAMPLE_W-1:0];
               CSR_GREEN_MIN: green_min = csr_data;
               CSR_GREEN_MAX: green_max = csr_data;
               CSR_AMBER:     amber_len = csr_data;
               CSR_AUX_BLINK: blink_len = csr_data;
               default: ;   // drop writes past the last register
            endcase
         end
         if (req_tvalid && req_tready)
            expected_views.push_back(advance_signals(req_tdata[31:0], req_tdata[43:32],
                                                     req_tdata[55:44]));
         if (rsp_tvalid && rsp_tready) begin
            got = signal_view_type'(rsp_tdata[12:0]);
            if (expected_views.size() == 0) begin
               $error("result with no poll outstanding: rsp_tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_views.pop_front();
               check_field("lamps_a", want.lamps_a, got.lamps_a);
               check_field("lamps_b", want.lamps_b, got.lamps_b);
               check_field("aux_leds", want.aux_leds, got.aux_leds);
               check_field("phase_code", want.phase_code, got.phase_code);
            end
         end
      end
      results_owed <= expected_views.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the traffic light controller. Directed polls walk
// every phase, the night entry and exit and the timing corner cases; then
// randomized traffic runs under six register settings with idling on both
// sides, a long result hold-off and drain pauses. The checker beside the
// block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb_top;
   import tlc_pkg::*;

   localparam int CLOCK_HALF        = 2;
   localparam int RESET_CYCLES      = 7;
   localparam int IDLE_LIMIT        = 4000;  // cycles with no transaction anywhere
   localparam int HOLD_CYCLES       = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES     = 8;     // well past the poll latency
   localparam int POLLS_PER_SETTING = 130;

   // indexes above CSR_AUX_BLINK up to this one must be dropped by the block
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LAST = '1;
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = '1;
   localparam logic [MS_W-1:0]      MS_MAX       = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [55:0]          req_tdata;    // now_ms[31:0], pot_sample[43:32], light_sample[55:44]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;    // lamps_a[2:0], lamps_b[5:3], aux_leds[9:6],
                                       // phase_code[12:10]
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MS_W-1:0]      csr_data;

   int unsigned          mismatch_count;
   int unsigned          results_owed;

   // traffic shaping
   int unsigned          sender_idle_pct;
   int unsigned          receiver_idle_pct;
   int unsigned          hold_requests;
   int unsigned          holds_served;
   int unsigned          idle_cycles;

   // poll generator state
   logic [TIME_W-1:0]    wall_ms;          // simulated free-running millisecond clock
   logic [SAMPLE_W-1:0]  dark_below;       // night threshold currently programmed
   int unsigned          step_max_ms;      // largest forward step between polls
   int unsigned          dark_polls_left;  // remaining polls of a night stretch

   traffic_light_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tlc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Result side: random back-pressure, or a long hold-off when one is
   // requested. The hold is counted here so the sender keeps offering polls
   // and the front end fills up and drops req_tready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Offer one poll, idling first at random, and hold it until accepted.
   // Valid stays high afterwards so back-to-back polls need no reassertion.
   task automatic send_poll(input logic [TIME_W-1:0]   now,
                            input logic [SAMPLE_W-1:0] pot,
                            input logic [SAMPLE_W-1:0] light);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {light, pot, now};
      do @(posedge clock); while (!req_tready);
   endtask

   // Pause the sender until every result is back, then let the pipe settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Program all five registers while the block is idle. The threshold write
   // carries junk in its upper bits, and a write to an unused index follows.
   task automatic apply_settings(input logic [SAMPLE_W-1:0] thr,
                                 input logic [MS_W-1:0]     gmin,
                                 input logic [MS_W-1:0]     gmax,
                                 input logic [MS_W-1:0]     amber,
                                 input logic [MS_W-1:0]     blink);
      drain_results();
      write_reg(CSR_NIGHT_THR, {4'($urandom), thr});
      write_reg(CSR_GREEN_MIN, gmin);
      write_reg(CSR_GREEN_MAX, gmax);
      write_reg(CSR_AMBER, amber);
      write_reg(CSR_AUX_BLINK, blink);
      write_reg(CSR_IDX_W'($urandom_range(CSR_AUX_BLINK + 1, CSR_IDX_LAST)), MS_W'($urandom));
      csr_valid <= 1'b0;
      dark_below = thr;
   endtask

   // Mostly a plausible clock moving forward with day readings, broken by
   // night stretches, clock jumps, backward steps and arbitrary light noise.
   task automatic send_random_poll();
      int unsigned         roll;
      logic [SAMPLE_W-1:0] pot;
      logic [SAMPLE_W-1:0] light;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         wall_ms = $urandom;
      else if (roll < 5)
         wall_ms = wall_ms - $urandom_range(0, 2000);
      else
         wall_ms = wall_ms + $urandom_range(0, step_max_ms);

      roll = $urandom_range(0, 99);
      if (roll < 10)
         pot = '0;
      else if (roll < 20)
         pot = SAMPLE_MAX;
      else
         pot = SAMPLE_W'($urandom);

      roll = $urandom_range(0, 99);
      if (dark_polls_left != 0) begin
         dark_polls_left--;
         light = (dark_below == '0) ? '0 : SAMPLE_W'($urandom_range(0, dark_below - 1));
      end else if (roll < 4) begin
         light = SAMPLE_W'($urandom);
      end else begin
         if (roll < 7) dark_polls_left = $urandom_range(1, 12);
         light = SAMPLE_W'($urandom_range(dark_below, SAMPLE_MAX));
      end
      send_poll(wall_ms, pot, light);
   endtask

   task automatic run_traffic(input int unsigned polls, input bit with_hold);
      for (int unsigned n = 0; n < polls; n++) begin
         if (with_hold && n == polls / 3) hold_requests++;
         send_random_poll();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      sender_idle_pct   = 36;
      receiver_idle_pct = 84;
      hold_requests     = 0;
      holds_served      = 0;
      wall_ms           = '0;
      dark_below        = NIGHT_THR_RST;
      step_max_ms       = 300;
      dark_polls_left   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed, registers at their defaults -------------------------
      // red at time zero, then a timeout across the clock wrap
      send_poll(32'd0, '0, SAMPLE_MAX);
      send_poll(32'hFFFF_FFFF, SAMPLE_MAX, SAMPLE_MAX);
      // red-yellow, timing out with the start time before the wrap
      send_poll(32'd100, '0, 12'd2000);
      send_poll(32'd2101, '0, 12'd2000);
      // light exactly at the threshold stays day; green times out at pot zero
      send_poll(32'd5101, '0, 12'd1500);
      // yellow blink: toggle, exactly the interval holds, one more toggles
      send_poll(32'd5200, '0, 12'd1500);
      send_poll(32'd5500, '0, 12'd1500);
      send_poll(32'd5501, '0, 12'd1500);
      // night entry on an odd flash slot, then an even one at the darkest reading
      send_poll(32'd5999, '0, 12'd1499);
      send_poll(32'd6000, '0, '0);
      // night exit restarts red; mid-scale pot truncates the green time
      send_poll(32'd6100, SAMPLE_MAX, SAMPLE_MAX);
      send_poll(32'd16100, 12'd2048, SAMPLE_MAX);

      // zero green and amber: night exit times out in the same poll, and a
      // zero blink interval toggles only when time moved
      apply_settings(SAMPLE_MAX, '0, '0, '0, '0);
      send_poll(32'd7000, 12'd77, '0);
      repeat (8) send_poll(32'd7000, 12'd77, SAMPLE_MAX);

      // --- random: sender idles 36 %, receiver 84 % -----------------------
      wall_ms     = 32'd20000;
      apply_settings(12'd1500, 16'd300, 16'd2000, 16'd200, 16'd50);
      step_max_ms = 300;
      run_traffic(POLLS_PER_SETTING, 1'b1);

      apply_settings(SAMPLE_MAX, '0, MS_MAX, '0, '0);
      step_max_ms = 3000;
      run_traffic(POLLS_PER_SETTING, 1'b0);

      // --- random: sender idles 84 %, receiver 36 % -----------------------
      sender_idle_pct   = 84;
      receiver_idle_pct = 36;
      // never night, maximum below minimum, longest amber and blink, near wrap
      apply_settings('0, 16'd1000, 16'd10, MS_MAX, MS_MAX);
      wall_ms     = 32'hFFFF_F000;
      step_max_ms = 4000;
      run_traffic(POLLS_PER_SETTING, 1'b0);

      apply_settings(SAMPLE_W'($urandom), MS_W'($urandom_range(0, 4000)),
                     MS_W'($urandom_range(0, 8000)), MS_W'($urandom_range(0, 1500)),
                     MS_W'($urandom_range(0, 500)));
      step_max_ms = 500;
      run_traffic(POLLS_PER_SETTING, 1'b0);

      // --- random: no idling on either side -------------------------------
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      apply_settings(12'd2048, '0, '0, 16'd1, MS_MAX);
      step_max_ms = 400;
      run_traffic(POLLS_PER_SETTING, 1'b0);

      apply_settings(NIGHT_THR_RST, GREEN_MIN_RST, GREEN_MAX_RST, AMBER_RST, AUX_BLINK_RST);
      step_max_ms = 1500;
      run_traffic(POLLS_PER_SETTING, 1'b1);

      drain_results();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tlc_pkg.sv
rtl/tlc_prep.sv
rtl/traffic_light_controller.sv
sim/tlc_checker.sv
sim/tb_top.sv
